// File: hdl/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked concurrent assertions, disabled while in reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge out of reset.
`define Z85_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true at a rising clock edge out of reset.
`define Z85_NEVER(lbl, expr, msg) \
  `Z85_ASSERT(lbl, !(expr), msg)

`endif

// File: hdl/z85_pkg.sv
// -----------------------------------------------------------------------------
// z85_pkg
// Shared types, constants and the Z85 alphabet for the byte stream encoder.
// -----------------------------------------------------------------------------
package z85_pkg;

  // Reciprocal of 85 scaled by 2^38; quotient estimate is exact or one low
  localparam logic [31:0] Z85_RECIP   = 32'd3233857728;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam int unsigned QW          = 26;  // quotient width for 32-bit input
  localparam logic [7:0]  Z85_BASE_8  = 8'd85;
  localparam int unsigned DIV_STEPS   = 4;   // divisions per 32-bit group
  localparam logic [1:0]  POS_LAST    = 2'd3;
  localparam logic [2:0]  GROUP_CHARS = 3'd5;
  localparam logic [2:0]  ERR_CHARS   = 3'd1;

  // One unit of work for the back end
  typedef struct packed {
    logic [31:0] word;
    logic        err;   // message ended on an incomplete group
    logic        fin;   // group or error closes the message
  } job_t;

  // Finished group handed from converter to output stage; dig[0] is MSB digit
  typedef struct packed {
    logic [4:0][6:0] dig;
    logic            err;
    logic            fin;
  } em_load_t;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_MUL,
    CV_COR
  } conv_state_e;

  // Base-85 digit to ASCII
  function automatic logic [6:0] z85_char(input logic [6:0] d);
    logic [6:0] c;
    c = 7'd0;
    case (d) inside
      [7'd0:7'd9]:   c = 7'd48 + d;
      [7'd10:7'd35]: c = 7'd87 + d;
      [7'd36:7'd61]: c = 7'd29 + d;
      7'd62: c = 7'(".");
      7'd63: c = 7'("-");
      7'd64: c = 7'(":");
      7'd65: c = 7'("+");
      7'd66: c = 7'("=");
      7'd67: c = 7'("^");
      7'd68: c = 7'("!");
      7'd69: c = 7'("/");
      7'd70: c = 7'("*");
      7'd71: c = 7'("?");
      7'd72: c = 7'("&");
      7'd73: c = 7'("<");
      7'd74: c = 7'(">");
      7'd75: c = 7'("(");
      7'd76: c = 7'(")");
      7'd77: c = 7'("[");
      7'd78: c = 7'("]");
      7'd79: c = 7'("{");
      7'd80: c = 7'("}");
      7'd81: c = 7'("@");
      7'd82: c = 7'("%");
      7'd83: c = 7'("$");
      7'd84: c = 7'("#");
      default: c = 7'd0;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/z85_byte_stream_encoder.sv
// -----------------------------------------------------------------------------
// z85_byte_stream_encoder
// Z85 encoder for a byte stream: four bytes in, five characters out.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel: drive data_byte_i and final_byte_i with push; a byte is
//   taken on a clock edge with push high and full low. Mark the last byte of
//   a message with final_byte_i.
//   Result channel: while empty is low the oldest character is on the result
//   ports; pop takes it. Every fourth byte yields five characters, most
//   significant digit first; group_end_o flags the fifth. A message whose
//   length is not a multiple of four ends in one result with status_o set.
//   Throughput: bytes enter at one per cycle until the job queue fills. The
//   converter works a group in four divide-by-85 steps, each a multiply and a
//   correction on one shared multiplier, and takes the next group only after
//   handing the current one to the output stage.
//   Reset clears the partial group, the job queue and the output stage.
//   A stalled receiver holds the head character; the converter and then the
//   queue fill behind it before full rises.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module z85_byte_stream_encoder import z85_pkg::*; #(
  parameter int unsigned JOBQ_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] character_o,
  output logic       group_end_o,
  output logic       message_end_o,
  output logic       status_o
);

  job_t     job_in, job_head;
  logic     job_push, job_valid, job_pop;
  logic     em_free, em_load_valid;
  em_load_t em_load;

  // Front end: byte gathering
  z85_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_byte_i (data_byte_i),
    .final_byte_i(final_byte_i),
    .full_i      (full),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  // Decoupling queue
  z85_jobq #(
    .DEPTH(JOBQ_DEPTH)
  ) u_jobq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .full_o (full),
    .pop_i  (job_pop),
    .data_o (job_head),
    .valid_o(job_valid)
  );

  // Back end: base-85 conversion
  z85_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .em_free_i   (em_free),
    .load_valid_o(em_load_valid),
    .load_o      (em_load)
  );

  // Back end: character output
  z85_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (em_load_valid),
    .load_i       (em_load),
    .free_o       (em_free),
    .pop          (pop),
    .empty        (empty),
    .character_o  (character_o),
    .group_end_o  (group_end_o),
    .message_end_o(message_end_o),
    .status_o     (status_o)
  );

  // Checks
  `Z85_NEVER(a_jobq_overflow, job_push && full, "job pushed into full queue")
  `Z85_NEVER(a_emit_overrun, em_load_valid && !em_free, "output stage overwritten")
  `Z85_ASSERT(a_err_shape, (!empty && status_o) |-> (group_end_o && message_end_o && (character_o == 7'd0)), "malformed error result")
  `Z85_ASSERT(a_group_continues, (!empty && pop && !group_end_o) |=> !empty, "group cut short")

endmodule

// File: hdl/z85_front.sv
// -----------------------------------------------------------------------------
// z85_front
// Collects input bytes into 32-bit groups and issues encode or error jobs.
// -----------------------------------------------------------------------------
module z85_front import z85_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  input  logic       full_i,
  output logic       job_push_o,
  output job_t       job_o
);

  logic [23:0] pend_q, pend_d;
  logic [1:0]  pos_q, pos_d;

  // Gather bytes big-endian; fourth byte or final flag closes the group
  always_comb begin
    pend_d     = pend_q;
    pos_d      = pos_q;
    job_push_o = 1'b0;
    job_o      = '0;
    if (push_i && !full_i) begin
      if (pos_q == POS_LAST) begin
        job_o.word = {pend_q, data_byte_i};
        job_o.fin  = final_byte_i;
        job_push_o = 1'b1;
        pend_d     = '0;
        pos_d      = '0;
      end else if (final_byte_i) begin
        job_o.err  = 1'b1;
        job_o.fin  = 1'b1;
        job_push_o = 1'b1;
        pend_d     = '0;
        pos_d      = '0;
      end else begin
        pend_d = {pend_q[15:0], data_byte_i};
        pos_d  = pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      pos_q  <= '0;
    end else begin
      pend_q <= pend_d;
      pos_q  <= pos_d;
    end
  end

endmodule

// File: hdl/z85_jobq.sv
// -----------------------------------------------------------------------------
// z85_jobq
// Small FIFO of jobs between the front end and the converter.
// -----------------------------------------------------------------------------
module z85_jobq import z85_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic valid_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          push_fire, pop_fire;

  assign full_o    = (cnt_q == CW'(DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign push_fire = push_i && !full_o;
  assign pop_fire  = pop_i && valid_o;
  assign data_o    = mem_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop_fire) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push_fire && !pop_fire) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_fire && !push_fire) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

// File: hdl/z85_conv.sv
// -----------------------------------------------------------------------------
// z85_conv
// Converts a 32-bit group to five base-85 digits by repeated division by 85.
// -----------------------------------------------------------------------------
module z85_conv import z85_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  input  job_t     job_i,
  output logic     job_pop_o,
  input  logic     em_free_i,
  output logic     load_valid_o,
  output em_load_t load_o
);

  conv_state_e       state_q, state_d;
  logic [1:0]        step_q, step_d;
  logic [31:0]       x_q, x_d;
  logic [QW-1:0]     qe_q, qe_d;
  logic [2:0][6:0]   dig_q, dig_d;
  logic              fin_q, fin_d;

  logic [31:0]       mul_in;
  logic [63:0]       prod;
  logic [7:0]        lo_prod, rem8;
  logic              fix;
  logic [6:0]        digit;
  logic [QW-1:0]     q_fixed;

  // Quotient estimate: one shared multiplier by the scaled reciprocal
  assign mul_in = (state_q == CV_IDLE) ? job_i.word : x_q;
  assign prod   = 64'(mul_in) * 64'(Z85_RECIP);

  // Correction: remainder is below 170, so the low byte is enough
  assign lo_prod = 8'(qe_q[7:0] * Z85_BASE_8);
  assign rem8    = x_q[7:0] - lo_prod;
  assign fix     = (rem8 >= Z85_BASE_8);
  assign digit   = fix ? 7'(rem8 - Z85_BASE_8) : rem8[6:0];
  assign q_fixed = qe_q + QW'(fix);

  // Sequencer: multiply, correct, four times per group; error jobs go straight to the output stage
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    x_d          = x_q;
    qe_d         = qe_q;
    dig_d        = dig_q;
    fin_d        = fin_q;
    job_pop_o    = 1'b0;
    load_valid_o = 1'b0;
    load_o       = '0;
    case (state_q)
      CV_IDLE: begin
        if (job_valid_i) begin
          if (job_i.err) begin
            if (em_free_i) begin
              job_pop_o    = 1'b1;
              load_valid_o = 1'b1;
              load_o.err   = 1'b1;
              load_o.fin   = job_i.fin;
            end
          end else begin
            job_pop_o = 1'b1;
            x_d       = job_i.word;
            qe_d      = prod[RECIP_SHIFT +: QW];
            fin_d     = job_i.fin;
            step_d    = '0;
            state_d   = CV_COR;
          end
        end
      end
      CV_MUL: begin
        qe_d    = prod[RECIP_SHIFT +: QW];
        state_d = CV_COR;
      end
      CV_COR: begin
        if (step_q != 2'(DIV_STEPS - 1)) begin
          x_d     = 32'(q_fixed);
          dig_d   = {dig_q[1:0], digit};
          step_d  = step_q + 2'd1;
          state_d = CV_MUL;
        end else if (em_free_i) begin
          // last quotient is the most significant digit
          load_valid_o = 1'b1;
          load_o.fin   = fin_q;
          load_o.dig   = {dig_q[2], dig_q[1], dig_q[0], digit, q_fixed[6:0]};
          state_d      = CV_IDLE;
        end
      end
      default: begin
        state_d = CV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CV_IDLE;
      step_q  <= '0;
      x_q     <= '0;
      qe_q    <= '0;
      dig_q   <= '0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      x_q     <= x_d;
      qe_q    <= qe_d;
      dig_q   <= dig_d;
      fin_q   <= fin_d;
    end
  end

endmodule

// File: hdl/z85_emit.sv
// -----------------------------------------------------------------------------
// z85_emit
// Output stage: holds one finished group and presents it one character a beat.
// -----------------------------------------------------------------------------
module z85_emit import z85_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_valid_i,
  input  em_load_t load_i,
  output logic     free_o,
  input  logic     pop,
  output logic     empty,
  output logic [6:0] character_o,
  output logic     group_end_o,
  output logic     message_end_o,
  output logic     status_o
);

  logic [4:0][6:0] dig_q;
  logic [2:0]      cnt_q;  // results left in the group, 0 when empty
  logic            err_q, fin_q;
  logic            pop_fire, last_beat;

  assign empty     = (cnt_q == '0);
  assign pop_fire  = pop && !empty;
  assign last_beat = (cnt_q == 3'd1);
  assign free_o    = empty || (pop_fire && last_beat);

  // Result fields for the head character
  assign character_o   = err_q ? 7'd0 : z85_char(dig_q[0]);
  assign group_end_o   = last_beat;
  assign message_end_o = last_beat && fin_q;
  assign status_o      = err_q;

  // Load a new group or shift to the next character on each beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      dig_q <= '0;
      err_q <= 1'b0;
      fin_q <= 1'b0;
    end else if (load_valid_i) begin
      cnt_q <= load_i.err ? ERR_CHARS : GROUP_CHARS;
      dig_q <= load_i.dig;
      err_q <= load_i.err;
      fin_q <= load_i.fin;
    end else if (pop_fire) begin
      cnt_q <= cnt_q - 3'd1;
      dig_q <= {7'd0, dig_q[4:1]};
    end
  end

endmodule
